// File: sv/ordered_list_with_key_delete_assert.svh
// Assertion macros used by the port-level checker file of the ordered list block.
// Both expect clk_i in scope, OLKD_ASSERT also rst_ni; no other dependencies.
`ifndef ORDERED_LIST_WITH_KEY_DELETE_ASSERT_SVH
`define ORDERED_LIST_WITH_KEY_DELETE_ASSERT_SVH

// Checked only outside reset.
`define OLKD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked on every edge, reset included.
`define OLKD_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// File: sv/olkd_pkg.sv
// Shared types, sizes and codes for the ordered list block.
// No dependencies; used by the top level, both checkers and the testbench.
package olkd_pkg;

  localparam int unsigned Depth     = 16;
  localparam int unsigned DataWidth = 32;
  localparam int unsigned ItemW     = 32;
  localparam int unsigned ActW      = 3;
  localparam int unsigned StatW     = 3;
  localparam int unsigned AddrW     = $clog2(Depth);
  localparam int unsigned CntW      = $clog2(Depth + 1);

  typedef logic [AddrW-1:0]     addr_t;
  typedef logic [CntW-1:0]      cnt_t;
  typedef logic [DataWidth-1:0] data_t;

  typedef enum logic [ActW-1:0] {
    ACT_APPEND   = 3'd0,
    ACT_POP_HEAD = 3'd1,
    ACT_POP_TAIL = 3'd2,
    ACT_REMOVE   = 3'd3,
    ACT_LIST     = 3'd4
  } act_e;

  typedef enum logic [StatW-1:0] {
    ST_APPENDED = 3'd0,
    ST_REMOVED  = 3'd1,
    ST_EMPTY    = 3'd2,
    ST_NOTFOUND = 3'd3,
    ST_FULL     = 3'd4,
    ST_LISTED   = 3'd5
  } stat_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_POP_RD,
    S_POP_OUT,
    S_SEARCH,
    S_SHIFT,
    S_LIST
  } state_e;

  // Physical slot of the entry at offset off from the head (off <= Depth).
  function automatic addr_t slot_of(addr_t head, cnt_t off);
    logic [CntW:0] sum;
    sum = (CntW+1)'(head) + (CntW+1)'(off);
    if (sum >= (CntW+1)'(Depth)) begin
      sum = sum - (CntW+1)'(Depth);
    end
    return AddrW'(sum);
  endfunction

endpackage

// File: sv/olkd_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module olkd_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// File: sv/ordered_list_with_key_delete.sv
// Top level of the ordered list with delete by value.
// Depends on olkd_pkg and olkd_ram.
//
// Use: an item (action_i, value_i) is taken at a clock edge with start high
// and busy low. Results come out on status_o/item_o/last_o, each valid for
// exactly one cycle while valid_o is high; last_o marks the final result of
// an item. The receiver cannot stall, so results are never held back.
// Path from the accepting edge to the result, by action:
//   append, full, empty: result in the next cycle, busy stays low.
//   unused action codes: no result, busy stays low.
//   remove head/tail: through S_POP_RD, the RAM read and S_POP_OUT.
//   remove by value: S_SEARCH reads from the head to the match; unless it is
//   the last entry, busy then holds in S_SHIFT while the tail closes up;
//   no match: the result comes with the check of the last entry.
//   list: one entry per cycle back to back from the head.
// All walks go through the single read port of the entry RAM, one entry per
// cycle; read data is registered. Reset empties the list; no clearing pass.
module ordered_list_with_key_delete (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start,
  input  logic [olkd_pkg::ActW-1:0]         action_i,
  input  logic signed [olkd_pkg::ItemW-1:0] value_i,
  output logic                              busy,
  output logic                              valid_o,
  output logic [olkd_pkg::StatW-1:0]        status_o,
  output logic signed [olkd_pkg::ItemW-1:0] item_o,
  output logic                              last_o
);
  import olkd_pkg::*;

  state_e state_q, state_d;
  addr_t  head_q, head_d;
  cnt_t   occ_q, occ_d;
  act_e   act_q, act_d;
  data_t  key_q, key_d;
  cnt_t   ridx_q, ridx_d;
  cnt_t   cidx_q, cidx_d;
  logic   rvld_q, rvld_d;
  logic   valid_q, valid_d;
  stat_e  status_q, status_d;
  logic signed [ItemW-1:0] item_q, item_d;
  logic   last_q, last_d;

  logic   we;
  addr_t  waddr, raddr;
  data_t  wdata, rdata;
  data_t  key_in;
  cnt_t   woff;
  logic   accept, hit, at_last, issue_more, empty, full;
  logic signed [ItemW-1:0] rd_item;

  olkd_ram #(
    .Width(DataWidth),
    .Depth(Depth)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  assign busy       = (state_q != S_IDLE);
  assign accept     = start && !busy;
  assign key_in     = DataWidth'(value_i);
  assign rd_item    = ItemW'($signed(rdata));
  assign empty      = (occ_q == '0);
  assign full       = (occ_q == cnt_t'(Depth));
  assign hit        = rvld_q && (rdata == key_q);
  assign at_last    = (cidx_q == occ_q - cnt_t'(1));
  assign issue_more = (ridx_q < occ_q);
  assign raddr      = slot_of(head_q, ridx_q);
  // Shift writes land one slot behind the entry just read; appends at the tail.
  assign woff       = (state_q == S_SHIFT) ? (cidx_q - cnt_t'(1)) : occ_q;
  assign waddr      = slot_of(head_q, woff);

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept && !empty) begin
          unique case (action_i)
            ACT_POP_HEAD, ACT_POP_TAIL: state_d = S_POP_RD;
            ACT_REMOVE:                 state_d = S_SEARCH;
            ACT_LIST:                   state_d = S_LIST;
            default:                    state_d = S_IDLE;
          endcase
        end
      end
      S_POP_RD:  state_d = S_POP_OUT;
      S_POP_OUT: state_d = S_IDLE;
      S_SEARCH: begin
        if (hit) begin
          state_d = at_last ? S_IDLE : S_SHIFT;
        end else if (rvld_q && at_last) begin
          state_d = S_IDLE;
        end
      end
      S_SHIFT, S_LIST: begin
        if (rvld_q && at_last) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Datapath and outputs
  always_comb begin
    head_d   = head_q;
    occ_d    = occ_q;
    act_d    = act_q;
    key_d    = key_q;
    ridx_d   = ridx_q;
    cidx_d   = cidx_q;
    rvld_d   = 1'b0;
    valid_d  = 1'b0;
    status_d = status_q;
    item_d   = item_q;
    last_d   = last_q;
    we       = 1'b0;
    wdata    = key_in;

    // Read stream for the walking states: one entry per cycle.
    if ((state_q == S_SEARCH || state_q == S_SHIFT || state_q == S_LIST) && issue_more) begin
      ridx_d = ridx_q + cnt_t'(1);
      cidx_d = ridx_q;
      rvld_d = 1'b1;
    end

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          act_d  = act_e'(action_i);
          key_d  = key_in;
          ridx_d = '0;
          unique case (action_i)
            ACT_APPEND: begin
              valid_d = 1'b1;
              last_d  = 1'b1;
              if (full) begin
                status_d = ST_FULL;
                item_d   = '0;
              end else begin
                we       = 1'b1;
                occ_d    = occ_q + cnt_t'(1);
                status_d = ST_APPENDED;
                item_d   = ItemW'($signed(key_in));
              end
            end
            ACT_POP_HEAD, ACT_POP_TAIL, ACT_REMOVE, ACT_LIST: begin
              if (empty) begin
                valid_d  = 1'b1;
                last_d   = 1'b1;
                status_d = ST_EMPTY;
                item_d   = '0;
              end else if (action_i == ACT_POP_TAIL) begin
                ridx_d = occ_q - cnt_t'(1);
              end
            end
            default: ;
          endcase
        end
      end
      S_POP_RD: ;
      S_POP_OUT: begin
        valid_d  = 1'b1;
        last_d   = 1'b1;
        status_d = ST_REMOVED;
        item_d   = rd_item;
        occ_d    = occ_q - cnt_t'(1);
        if (act_q == ACT_POP_HEAD) begin
          head_d = slot_of(head_q, cnt_t'(1));
        end
      end
      S_SEARCH: begin
        if (hit) begin
          valid_d  = 1'b1;
          last_d   = 1'b1;
          status_d = ST_REMOVED;
          item_d   = rd_item;
          if (at_last) begin
            occ_d = occ_q - cnt_t'(1);
          end else begin
            // restart the stream just behind the match
            ridx_d = cidx_q + cnt_t'(1);
            rvld_d = 1'b0;
          end
        end else if (rvld_q && at_last) begin
          valid_d  = 1'b1;
          last_d   = 1'b1;
          status_d = ST_NOTFOUND;
          item_d   = '0;
        end
      end
      S_SHIFT: begin
        if (rvld_q) begin
          we    = 1'b1;
          wdata = rdata;
          if (at_last) begin
            occ_d = occ_q - cnt_t'(1);
          end
        end
      end
      S_LIST: begin
        if (rvld_q) begin
          valid_d  = 1'b1;
          last_d   = at_last;
          status_d = ST_LISTED;
          item_d   = rd_item;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      head_q  <= '0;
      occ_q   <= '0;
      rvld_q  <= 1'b0;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      occ_q   <= occ_d;
      rvld_q  <= rvld_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    act_q    <= act_d;
    key_q    <= key_d;
    ridx_q   <= ridx_d;
    cidx_q   <= cidx_d;
    status_q <= status_d;
    item_q   <= item_d;
    last_q   <= last_d;
  end

  assign valid_o  = valid_q;
  assign status_o = status_q;
  assign item_o   = item_q;
  assign last_o   = last_q;

endmodule

// File: sv/olkd_chk.sv
// Port-level checker for the ordered list block, bound to the top level.
// Depends on olkd_pkg and ordered_list_with_key_delete_assert.svh.
`include "ordered_list_with_key_delete_assert.svh"

module olkd_chk (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              start,
  input logic signed [olkd_pkg::ItemW-1:0] value_i,
  input logic                              busy,
  input logic                              valid_o,
  input logic [olkd_pkg::StatW-1:0]        status_o,
  input logic signed [olkd_pkg::ItemW-1:0] item_o,
  input logic                              last_o
);
  import olkd_pkg::*;

  // From the edge after reset is seen the block is quiet; the first edge may see unreset flops.
  `OLKD_ASSERT_ALWAYS(a_reset_quiet, !rst_ni |=> (!valid_o && !busy), "active while in reset")
  `OLKD_ASSERT(a_list_back_to_back, (valid_o && !last_o) |=> valid_o, "gap inside a listing")
  `OLKD_ASSERT(a_only_list_continues, (valid_o && !last_o) |-> (status_o == ST_LISTED), "non-last result that is not a listed entry")
  `OLKD_ASSERT(a_append_next_cycle, (valid_o && status_o == ST_APPENDED) |-> ($past(start && !busy) && ($past(value_i) == item_o)), "append result not the item just taken")
  `OLKD_ASSERT(a_result_has_cause, valid_o |-> ($past(busy) || $past(start)), "result without an item in flight")

endmodule

bind ordered_list_with_key_delete olkd_chk u_olkd_chk (.*);

// File: dv/olkd_checker.sv
// Result checker for the ordered list block: keeps its own copy of the list,
// predicts the results of every accepted item and compares them on arrival.
// Depends on olkd_pkg for sizes and action/status codes.
module olkd_checker (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic                              busy_i,
  input  logic [olkd_pkg::ActW-1:0]         action_i,
  input  logic signed [olkd_pkg::ItemW-1:0] value_i,
  input  logic                              valid_i,
  input  logic [olkd_pkg::StatW-1:0]        status_i,
  input  logic signed [olkd_pkg::ItemW-1:0] item_i,
  input  logic                              last_i,
  output int                                fail_count_o,
  output int                                pending_o,
  output int                                checked_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import olkd_pkg::*;

  typedef struct packed {
    stat_e            status;
    logic [ItemW-1:0] item;
    logic             last;
  } list_result_t;

  data_t        slots_q [Depth];
  addr_t        head_q;
  cnt_t         occ_q;
  list_result_t awaited_q [$];
  int           fails;
  int           checked;

  function automatic addr_t slot_at(int off);
    return addr_t'((int'(head_q) + off) % Depth);
  endfunction

  function automatic void push_result(stat_e s, data_t v, logic l);
    awaited_q.push_back('{status: s, item: v, last: l});
  endfunction

  // Applies one item to the shadow list and queues what it should produce.
  function automatic void predict_item(logic [ActW-1:0] act, data_t key);
    int hit;
    hit = -1;
    case (act)
      ACT_APPEND: begin
        if (occ_q == cnt_t'(Depth)) begin
          push_result(ST_FULL, '0, 1'b1);
        end else begin
          slots_q[slot_at(int'(occ_q))] = key;
          occ_q = occ_q + cnt_t'(1);
          push_result(ST_APPENDED, key, 1'b1);
        end
      end
      ACT_POP_HEAD: begin
        if (occ_q == '0) begin
          push_result(ST_EMPTY, '0, 1'b1);
        end else begin
          push_result(ST_REMOVED, slots_q[head_q], 1'b1);
          head_q = slot_at(1);
          occ_q = occ_q - cnt_t'(1);
        end
      end
      ACT_POP_TAIL: begin
        if (occ_q == '0) begin
          push_result(ST_EMPTY, '0, 1'b1);
        end else begin
          push_result(ST_REMOVED, slots_q[slot_at(int'(occ_q) - 1)], 1'b1);
          occ_q = occ_q - cnt_t'(1);
        end
      end
      ACT_REMOVE: begin
        if (occ_q == '0) begin
          push_result(ST_EMPTY, '0, 1'b1);
        end else begin
          for (int i = 0; i < int'(occ_q); i++) begin
            if (hit < 0 && slots_q[slot_at(i)] == key) hit = i;
          end
          if (hit < 0) begin
            push_result(ST_NOTFOUND, '0, 1'b1);
          end else begin
            push_result(ST_REMOVED, slots_q[slot_at(hit)], 1'b1);
            // entries behind the hit move up one place
            for (int j = hit; j + 1 < int'(occ_q); j++) begin
              slots_q[slot_at(j)] = slots_q[slot_at(j + 1)];
            end
            occ_q = occ_q - cnt_t'(1);
          end
        end
      end
      ACT_LIST: begin
        if (occ_q == '0) begin
          push_result(ST_EMPTY, '0, 1'b1);
        end else begin
          for (int i = 0; i < int'(occ_q); i++) begin
            push_result(ST_LISTED, slots_q[slot_at(i)], (i + 1 == int'(occ_q)));
          end
        end
      end
      default: ;  // unused codes: no result, no change
    endcase
  endfunction

  function automatic void flag_mismatch(string what, list_result_t want);
    fails++;
    if (fails <= 10) begin
      $display("%0t ns: %s: expected status %0d item %0d last %0d, got status %0d item %0d last %0d",
               $time, what, want.status, $signed(want.item), want.last,
               status_i, item_i, last_i);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    list_result_t want;
    if (!rst_ni) begin
      head_q = '0;
      occ_q = '0;
      awaited_q.delete();
      fails = 0;
      checked = 0;
      fail_count_o <= 0;
      pending_o <= 0;
      checked_o <= 0;
    end else begin
      if (valid_i) begin
        checked++;
        if (awaited_q.size() == 0) begin
          flag_mismatch("result with nothing outstanding", '0);
        end else begin
          want = awaited_q.pop_front();
          if (status_i !== want.status || item_i !== want.item || last_i !== want.last) begin
            flag_mismatch("result mismatch", want);
          end
        end
      end
      if (start_i && !busy_i) predict_item(action_i, value_i);
      fail_count_o <= fails;
      pending_o <= awaited_q.size();
      checked_o <= checked;
    end
  end

endmodule

// File: dv/tb_top.sv
// Testbench top for the ordered list block: clock, reset, directed and
// random items, and the final verdict. Depends on olkd_pkg, the block and
// olkd_checker.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import olkd_pkg::*;

  logic                    clk_i;
  logic                    rst_ni = 1'b0;
  logic                    start = 1'b0;
  logic [ActW-1:0]         action_i = '0;
  logic signed [ItemW-1:0] value_i = '0;
  logic                    busy;
  logic                    valid_o;
  logic [StatW-1:0]        status_o;
  logic signed [ItemW-1:0] item_o;
  logic                    last_o;

  int fail_count;
  int pending;
  int checked;
  int items_sent = 0;
  int ignored = 0;

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  ordered_list_with_key_delete dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .action_i (action_i),
    .value_i  (value_i),
    .busy     (busy),
    .valid_o  (valid_o),
    .status_o (status_o),
    .item_o   (item_o),
    .last_o   (last_o)
  );

  olkd_checker u_list_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start),
    .busy_i       (busy),
    .action_i     (action_i),
    .value_i      (value_i),
    .valid_i      (valid_o),
    .status_i     (status_o),
    .item_i       (item_o),
    .last_i       (last_o),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .checked_o    (checked)
  );

  initial begin
    #2_000_000;
    $display("timeout with %0d results outstanding", pending);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Small pool so that removals by value hit, duplicates included.
  function automatic logic [ItemW-1:0] pool_value();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      2: return 32'h7FFF_FFFF;
      3: return 32'h8000_0000;
      4: return 32'd1;
      5: return 32'h5555_5555;
      6: return 32'hAAAA_AAAA;
      default: return 32'd42;
    endcase
  endfunction

  // Holds start high until the item is taken; start is left high.
  task automatic send_item(logic [ActW-1:0] act, logic [ItemW-1:0] val);
    start <= 1'b1;
    action_i <= act;
    value_i <= val;
    do @(posedge clk_i); while (busy);
    items_sent++;
    if (act > ACT_LIST) ignored++;
  endtask

  task automatic sender_gap(int pct);
    while ($urandom_range(0, 99) < pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  task automatic random_item(int append_pct);
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 3) begin
      send_item(ActW'($urandom_range(5, 7)), $urandom);
    end else if ($urandom_range(0, 99) < append_pct) begin
      send_item(ACT_APPEND, ($urandom_range(0, 99) < 65) ? pool_value() : $urandom);
    end else begin
      roll = $urandom_range(0, 99);
      if (roll < 40) begin
        send_item(ACT_REMOVE, ($urandom_range(0, 99) < 75) ? pool_value() : $urandom);
      end else if (roll < 60) begin
        send_item(ACT_POP_HEAD, $urandom);
      end else if (roll < 80) begin
        send_item(ACT_POP_TAIL, $urandom);
      end else begin
        send_item(ACT_LIST, $urandom);
      end
    end
  endtask

  initial begin : stimulus
    int idle_pct;
    int bias;
    int seg_left;
    logic [ItemW-1:0] val;

    bias = 50;
    seg_left = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty store, unused code
    send_item(ACT_LIST, '0);
    send_item(ACT_POP_HEAD, '0);
    send_item(ACT_POP_TAIL, '0);
    send_item(ACT_REMOVE, '0);
    send_item(ActW'(7), '1);
    // fill to full with extremes and a duplicate
    for (int i = 0; i < Depth; i++) begin
      case (i)
        0: val = 32'h8000_0000;
        1: val = 32'h7FFF_FFFF;
        2: val = '0;
        3: val = '1;
        9: val = 32'h7FFF_FFFF;
        default: val = i * 32'h0101_0101;
      endcase
      send_item(ACT_APPEND, val);
    end
    send_item(ACT_APPEND, 32'd5);
    send_item(ACT_LIST, '0);
    send_item(ACT_REMOVE, 32'h1234_5678);
    send_item(ACT_REMOVE, 32'h7FFF_FFFF);
    send_item(ACT_POP_HEAD, '0);
    send_item(ACT_APPEND, 32'hDEAD_BEEF);  // lands in the last physical slot, just before the wrap point
    send_item(ACT_LIST, '0);
    wait_drained();

    for (int ph = 0; ph < 3; ph++) begin
      idle_pct = (ph == 0) ? 37 : (ph == 1) ? 75 : 0;
      while (items_sent < 30 + (ph + 1) * 110) begin
        // segments that push toward full, hover, or drain
        seg_left--;
        if (seg_left <= 0) begin
          seg_left = 24;
          case ($urandom_range(0, 2))
            0: bias = 85;
            1: bias = 50;
            default: bias = 20;
          endcase
        end
        sender_gap(idle_pct);
        random_item(bias);
        if ($urandom_range(0, 99) == 0) wait_drained();
      end
      wait_drained();
    end

    // room for a trailing compaction or stray result
    repeat (Depth + 4) @(posedge clk_i);

    $display("Covered %0d items (%0d with unused action codes) under three sender idle profiles,",
             items_sent, ignored);
    $display("with %0d results checked against the predicted list.", checked);
    if (fail_count == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("%0d failures, %0d results never arrived", fail_count, pending);
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
